// ----- rtl/core/nos_pkg.sv -----
package nos_pkg;

  // item field widths
  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 22;
  localparam int SIZE_W   = 20;
  localparam int KIND_W   = 3;
  localparam int OPC_W    = 3;
  localparam int BLK_W    = 8;
  localparam int PG_W     = 6;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 9;
  localparam int BUF_W    = 16;
  localparam int TMO_W    = 16;

  // byte counter, holds size plus an in-block start
  localparam int CNT_W = 22;

  // register port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam int DEF_PAGE_BYTES      = 256;
  localparam int DEF_PAGES_PER_BLOCK = 64;
  localparam int DEF_MAX_UNITS       = 20;

  localparam logic [TMO_W-1:0] RST_READ_TMO  = 16'd1000;
  localparam logic [TMO_W-1:0] RST_PROG_TMO  = 16'd2000;
  localparam logic [TMO_W-1:0] RST_ERASE_TMO = 16'd10000;

  typedef enum logic [1:0] {
    REG_READ_TMO  = 2'd0,
    REG_PROG_TMO  = 2'd1,
    REG_ERASE_TMO = 2'd2
  } nos_reg_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_PROG  = 2'd1,
    ACT_ERASE = 2'd2
  } nos_act_t;

  typedef enum logic [KIND_W-1:0] {
    K_CMD  = 3'd0,
    K_ADDR = 3'd1,
    K_DIN  = 3'd2,
    K_DOUT = 3'd3,
    K_WAIT = 3'd4,
    K_REJ  = 3'd5
  } nos_kind_t;

  typedef enum logic [OPC_W-1:0] {
    OP_RD_SETUP = 3'd0,
    OP_RD_EXEC  = 3'd1,
    OP_PG_SETUP = 3'd2,
    OP_PG_EXEC  = 3'd3,
    OP_ER_SETUP = 3'd4,
    OP_ER_EXEC  = 3'd5
  } nos_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_BLK,
    ST_DIV_PG,
    ST_CHECK,
    ST_REJ,
    ST_SETUP,
    ST_ADDR,
    ST_UNIT
  } nos_state_t;

  typedef struct packed {
    logic [TMO_W-1:0] rd;
    logic [TMO_W-1:0] pg;
    logic [TMO_W-1:0] er;
  } nos_tmo_t;

endpackage

// ----- rtl/core/nos_if.sv -----
interface nos_in_if;
  logic                          valid;
  logic                          ready;
  logic [nos_pkg::ACTION_W-1:0]  action;
  logic [nos_pkg::OFFSET_W-1:0]  offset;
  logic [nos_pkg::SIZE_W-1:0]    transfer_size;

  modport source (output valid, action, offset, transfer_size, input ready);
  modport sink   (input valid, action, offset, transfer_size, output ready);
endinterface

interface nos_out_if;
  logic                        valid;
  logic                        ready;
  logic [nos_pkg::KIND_W-1:0]  instr_kind;
  logic [nos_pkg::OPC_W-1:0]   opcode;
  logic                        addr_full;
  logic [nos_pkg::BLK_W-1:0]   addr_block;
  logic [nos_pkg::PG_W-1:0]    addr_page;
  logic [nos_pkg::BYTE_W-1:0]  addr_byte;
  logic [nos_pkg::LEN_W-1:0]   chunk_length;
  logic [nos_pkg::BUF_W-1:0]   buffer_offset;
  logic [nos_pkg::TMO_W-1:0]   wait_timeout;
  logic                        last;

  modport source (output valid, instr_kind, opcode, addr_full, addr_block, addr_page,
                  addr_byte, chunk_length, buffer_offset, wait_timeout, last,
                  input ready);
  modport sink   (input valid, instr_kind, opcode, addr_full, addr_block, addr_page,
                  addr_byte, chunk_length, buffer_offset, wait_timeout, last,
                  output ready);
endinterface

// ----- rtl/core/nos_regs.sv -----
module nos_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nos_pkg::APB_AW-1:0]  paddr,
  input  logic [nos_pkg::APB_DW-1:0]  pwdata,
  output logic [nos_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output nos_pkg::nos_tmo_t           tmo
);
  import nos_pkg::*;

  nos_tmo_t tmo_r, tmo_nxt;
  nos_reg_t idx;
  logic     wr;

  assign idx    = nos_reg_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign tmo    = tmo_r;

  always_comb begin
    tmo_nxt = tmo_r;
    if (wr) begin
      case (idx)
        REG_READ_TMO:  tmo_nxt.rd = pwdata[TMO_W-1:0];
        REG_PROG_TMO:  tmo_nxt.pg = pwdata[TMO_W-1:0];
        REG_ERASE_TMO: tmo_nxt.er = pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_READ_TMO:  prdata = APB_DW'(tmo_r.rd);
      REG_PROG_TMO:  prdata = APB_DW'(tmo_r.pg);
      REG_ERASE_TMO: prdata = APB_DW'(tmo_r.er);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r.rd <= RST_READ_TMO;
      tmo_r.pg <= RST_PROG_TMO;
      tmo_r.er <= RST_ERASE_TMO;
    end else begin
      tmo_r <= tmo_nxt;
    end
  end

endmodule

// ----- rtl/core/nos_div.sv -----
module nos_div #(
  parameter int DW   = 22,
  parameter int VW   = 15,
  parameter int D_HI = 16384,
  parameter int D_LO = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          sel_lo,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  // q = (x * ceil(2^s / d)) >> s with s = DW + ceil(log2(d)) is exact for any DW-bit x
  localparam int MW   = DW + 2;
  localparam int PW   = DW + MW;
  localparam int S_HI = DW + $clog2(D_HI);
  localparam int S_LO = DW + $clog2(D_LO);
  localparam longint unsigned M_HI =
    ((64'd1 << S_HI) + 64'(D_HI) - 64'd1) / 64'(D_HI);
  localparam longint unsigned M_LO =
    ((64'd1 << S_LO) + 64'(D_LO) - 64'd1) / 64'(D_LO);

  logic          sel_r, sel_nxt;
  logic [DW-1:0] x_r, x_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic          mul_r, mul_nxt;
  logic          sub_r, sub_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] op_a;
  logic [MW-1:0] op_b;
  logic [PW-1:0] prod;

  // one multiplier: reciprocal product first, then quotient times divisor
  always_comb begin
    op_a = mul_r ? x_r : quo_r;
    if (mul_r) begin
      op_b = sel_r ? MW'(M_LO) : MW'(M_HI);
    end else begin
      op_b = sel_r ? MW'(D_LO) : MW'(D_HI);
    end
    prod     = PW'(op_a) * PW'(op_b);
    sel_nxt  = sel_r;
    x_nxt    = x_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    mul_nxt  = 1'b0;
    sub_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt   = dividend;
      sel_nxt = sel_lo;
      mul_nxt = 1'b1;
    end else if (mul_r) begin
      quo_nxt = sel_r ? DW'(prod >> S_LO) : DW'(prod >> S_HI);
      sub_nxt = 1'b1;
    end else if (sub_r) begin
      rem_nxt  = x_r[VW-1:0] - prod[VW-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    x_r   <= x_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/nand_operation_sequencer.sv -----
// Turns one read, program or erase request into its list of NAND instructions, one
// instruction beat per cycle on out_ch while the sink is ready. A request is taken
// only while the block is idle. The shared reciprocal multiplier then splits the start
// offset into block, page and byte, the block split first and then the page split. The
// unit-count check follows, then the n instructions (1 to 62), which wait while the sink
// holds ready low, and the block then goes back to idle to take the next request.
// Timeouts come from three 16-bit registers at byte addresses 0, 4 and 8.
module nand_operation_sequencer #(
  parameter int PAGE_BYTES      = nos_pkg::DEF_PAGE_BYTES,
  parameter int PAGES_PER_BLOCK = nos_pkg::DEF_PAGES_PER_BLOCK,
  parameter int MAX_UNITS       = nos_pkg::DEF_MAX_UNITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nos_in_if.sink                      in_ch,
  nos_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nos_pkg::APB_AW-1:0]  paddr,
  input  logic [nos_pkg::APB_DW-1:0]  pwdata,
  output logic [nos_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import nos_pkg::*;

  localparam int BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
  localparam int VW          = $clog2(BLOCK_BYTES + 1);
  localparam int BW          = $clog2(PAGE_BYTES);
  localparam logic [31:0] PG_LIM = 32'(MAX_UNITS * PAGE_BYTES);
  localparam logic [31:0] ER_LIM = 32'(MAX_UNITS * BLOCK_BYTES);

  nos_tmo_t tmo;

  nos_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tmo     (tmo)
  );

  nos_state_t          state_r, state_nxt;
  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [VW-1:0]       remb_r, remb_nxt;
  logic [PG_W-1:0]     pg_r, pg_nxt;
  logic [BW-1:0]       byt_r, byt_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VW-1:0]       avail_r, avail_nxt;
  logic [BUF_W-1:0]    cursor_r, cursor_nxt;
  logic [1:0]          phase_r, phase_nxt;

  logic                out_valid_r;
  nos_kind_t           o_kind_r;
  nos_op_t             o_op_r;
  logic                o_full_r;
  logic [BLK_W-1:0]    o_blk_r;
  logic [PG_W-1:0]     o_pg_r;
  logic [BYTE_W-1:0]   o_byte_r;
  logic [LEN_W-1:0]    o_len_r;
  logic [BUF_W-1:0]    o_buf_r;
  logic [TMO_W-1:0]    o_tmo_r;
  logic                o_last_r;

  // shared divider
  logic                div_start, div_done, div_sel_lo;
  logic [OFFSET_W-1:0] div_dividend, div_quo;
  logic [VW-1:0]       div_rem;

  logic accept;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign div_start    = accept || (state_r == ST_DIV_BLK && div_done);
  assign div_dividend = (state_r == ST_IDLE) ? in_ch.offset : OFFSET_W'(div_rem);
  // page split starts once the block split is done
  assign div_sel_lo   = (state_r != ST_IDLE);

  nos_div #(
    .DW   (OFFSET_W),
    .VW   (VW),
    .D_HI (BLOCK_BYTES),
    .D_LO (PAGE_BYTES)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sel_lo    (div_sel_lo),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic             is_erase, is_prog, bad_act, too_many, unit_last;
  logic [CNT_W-1:0] span_er, span_pg, step, len;
  logic [1:0]       last_phase;

  always_comb begin
    is_erase   = (action_r == ACT_ERASE);
    is_prog    = (action_r == ACT_PROG);
    bad_act    = !(action_r inside {ACT_READ, ACT_PROG, ACT_ERASE});
    span_er    = CNT_W'(size_r) + CNT_W'(remb_r);
    span_pg    = CNT_W'(size_r) + CNT_W'(byt_r);
    too_many   = is_erase ? (32'(span_er) > ER_LIM) : (32'(span_pg) > PG_LIM);
    step       = CNT_W'(avail_r);
    unit_last  = (cnt_r <= step);
    len        = unit_last ? cnt_r : step;
    last_phase = is_erase ? 2'd1 : 2'd2;
  end

  // instruction for the current step
  logic              e_valid;
  nos_kind_t         e_kind;
  nos_op_t           e_op;
  logic              e_full;
  logic [BLK_W-1:0]  e_blk;
  logic [PG_W-1:0]   e_pg;
  logic [BYTE_W-1:0] e_byte;
  logic [LEN_W-1:0]  e_len;
  logic [BUF_W-1:0]  e_buf;
  logic [TMO_W-1:0]  e_tmo;
  logic              e_last;
  logic              out_free, fire;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = e_valid && out_free;

  always_comb begin
    e_valid = 1'b0;
    e_kind  = K_CMD;
    e_op    = OP_RD_SETUP;
    e_full  = 1'b0;
    e_blk   = '0;
    e_pg    = '0;
    e_byte  = '0;
    e_len   = '0;
    e_buf   = '0;
    e_tmo   = '0;
    e_last  = 1'b0;
    case (state_r)
      ST_REJ: begin
        e_valid = 1'b1;
        e_kind  = K_REJ;
        e_last  = 1'b1;
      end
      ST_SETUP: begin
        e_valid = 1'b1;
        e_op    = is_erase ? OP_ER_SETUP : (is_prog ? OP_PG_SETUP : OP_RD_SETUP);
      end
      ST_ADDR: begin
        e_valid = 1'b1;
        e_kind  = K_ADDR;
        e_full  = !is_erase;
        e_blk   = blk_r;
        e_pg    = is_erase ? '0 : pg_r;
        e_byte  = is_erase ? '0 : BYTE_W'(byt_r);
        e_last  = (cnt_r == '0);
      end
      ST_UNIT: begin
        e_valid = 1'b1;
        e_last  = unit_last && (phase_r == last_phase);
        if (is_erase) begin
          if (phase_r == 2'd0) begin
            e_op = OP_ER_EXEC;
          end else begin
            e_kind = K_WAIT;
            e_tmo  = tmo.er;
          end
        end else if (is_prog) begin
          case (phase_r)
            2'd0: begin
              e_kind = K_DIN;
              e_len  = LEN_W'(len);
              e_buf  = cursor_r;
            end
            2'd1: e_op = OP_PG_EXEC;
            default: begin
              e_kind = K_WAIT;
              e_tmo  = tmo.pg;
            end
          endcase
        end else begin
          case (phase_r)
            2'd0: e_op = OP_RD_EXEC;
            2'd1: begin
              e_kind = K_WAIT;
              e_tmo  = tmo.rd;
            end
            default: begin
              e_kind = K_DOUT;
              e_len  = LEN_W'(len);
              e_buf  = cursor_r;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_DIV_BLK;
      ST_DIV_BLK: if (div_done) state_nxt = ST_DIV_PG;
      ST_DIV_PG:  if (div_done) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = (bad_act || too_many) ? ST_REJ : ST_SETUP;
      ST_REJ:     if (fire) state_nxt = ST_IDLE;
      ST_SETUP:   if (fire) state_nxt = ST_ADDR;
      ST_ADDR:    if (fire) state_nxt = (cnt_r == '0) ? ST_IDLE : ST_UNIT;
      ST_UNIT: begin
        if (fire && phase_r == last_phase && unit_last) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    action_nxt = action_r;
    size_nxt   = size_r;
    blk_nxt    = blk_r;
    remb_nxt   = remb_r;
    pg_nxt     = pg_r;
    byt_nxt    = byt_r;
    cnt_nxt    = cnt_r;
    avail_nxt  = avail_r;
    cursor_nxt = cursor_r;
    phase_nxt  = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          action_nxt = in_ch.action;
          size_nxt   = in_ch.transfer_size;
        end
      end
      ST_DIV_BLK: begin
        if (div_done) begin
          blk_nxt  = BLK_W'(div_quo);
          remb_nxt = div_rem;
        end
      end
      ST_DIV_PG: begin
        if (div_done) begin
          pg_nxt  = PG_W'(div_quo);
          byt_nxt = div_rem[BW-1:0];
        end
      end
      ST_CHECK: begin
        cnt_nxt    = is_erase ? span_er : CNT_W'(size_r);
        avail_nxt  = is_erase ? VW'(BLOCK_BYTES) : VW'(PAGE_BYTES) - VW'(byt_r);
        cursor_nxt = '0;
        phase_nxt  = '0;
      end
      ST_UNIT: begin
        if (fire) begin
          if (phase_r == last_phase) begin
            phase_nxt  = '0;
            cnt_nxt    = cnt_r - len;
            cursor_nxt = cursor_r + BUF_W'(len);
            // only the first page is shortened by the in-page start
            avail_nxt  = is_erase ? VW'(BLOCK_BYTES) : VW'(PAGE_BYTES);
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) out_valid_r <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    size_r   <= size_nxt;
    blk_r    <= blk_nxt;
    remb_r   <= remb_nxt;
    pg_r     <= pg_nxt;
    byt_r    <= byt_nxt;
    cnt_r    <= cnt_nxt;
    avail_r  <= avail_nxt;
    cursor_r <= cursor_nxt;
    phase_r  <= phase_nxt;
    if (fire) begin
      o_kind_r <= e_kind;
      o_op_r   <= e_op;
      o_full_r <= e_full;
      o_blk_r  <= e_blk;
      o_pg_r   <= e_pg;
      o_byte_r <= e_byte;
      o_len_r  <= e_len;
      o_buf_r  <= e_buf;
      o_tmo_r  <= e_tmo;
      o_last_r <= e_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.instr_kind    = o_kind_r;
  assign out_ch.opcode        = o_op_r;
  assign out_ch.addr_full     = o_full_r;
  assign out_ch.addr_block    = o_blk_r;
  assign out_ch.addr_page     = o_pg_r;
  assign out_ch.addr_byte     = o_byte_r;
  assign out_ch.chunk_length  = o_len_r;
  assign out_ch.buffer_offset = o_buf_r;
  assign out_ch.wait_timeout  = o_tmo_r;
  assign out_ch.last          = o_last_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a request is in progress");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UNIT |-> phase_r <= last_phase)
    else $error("unit phase beyond its last instruction");

  a_unit_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UNIT |-> cnt_r != '0)
    else $error("unit step with no bytes left");

  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_kind_r == K_REJ |-> o_last_r)
    else $error("rejected beat without last");
`endif

endmodule

// ----- dv/nos_sequence_checker.sv -----
`timescale 1ns / 100ps

module nos_sequence_checker
  import nos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nos_in_if                 in_ch,
  nos_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                expected_left
);

  localparam int PAGE_BYTES  = DEF_PAGE_BYTES;
  localparam int BLOCK_BYTES = DEF_PAGE_BYTES * DEF_PAGES_PER_BLOCK;
  localparam int MAX_UNITS   = DEF_MAX_UNITS;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OPC_W-1:0]  opcode;
    logic              full;
    logic [BLK_W-1:0]  blk;
    logic [PG_W-1:0]   pg;
    logic [BYTE_W-1:0] byt;
    logic [LEN_W-1:0]  len;
    logic [BUF_W-1:0]  bufpos;
    logic [TMO_W-1:0]  tmo;
    logic              last;
  } nand_instr_t;

  nos_tmo_t    tmo_regs;
  nand_instr_t instr_expect_q[$];
  nand_instr_t got_instr;

  function automatic nand_instr_t make_instr(logic [KIND_W-1:0] kind, logic [OPC_W-1:0] opcode,
                                             logic full, int unsigned blk, int unsigned pg,
                                             int unsigned byt, int unsigned len,
                                             int unsigned bufpos, logic [TMO_W-1:0] tmo);
    nand_instr_t it;
    it.kind   = kind;
    it.opcode = opcode;
    it.full   = full;
    it.blk    = BLK_W'(blk);
    it.pg     = PG_W'(pg);
    it.byt    = BYTE_W'(byt);
    it.len    = LEN_W'(len);
    it.bufpos = BUF_W'(bufpos);
    it.tmo    = tmo;
    it.last   = 1'b0;
    return it;
  endfunction

  // turns one request into the instruction list it should produce
  function automatic void expand_request(logic [ACTION_W-1:0] action,
                                         logic [OFFSET_W-1:0] offset,
                                         logic [SIZE_W-1:0] size);
    nand_instr_t seq[$];
    nand_instr_t it;
    int unsigned blk, pg, byt, span, units, remaining, cursor, avail, len;
    blk = offset / BLOCK_BYTES;
    pg  = (offset % BLOCK_BYTES) / PAGE_BYTES;
    byt = offset % PAGE_BYTES;
    case (action)
      ACT_ERASE: begin
        span  = size + offset % BLOCK_BYTES;
        units = (span + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (units > MAX_UNITS) begin
          seq.push_back(make_instr(K_REJ, '0, 1'b0, 0, 0, 0, 0, 0, '0));
        end else begin
          seq.push_back(make_instr(K_CMD, OP_ER_SETUP, 1'b0, 0, 0, 0, 0, 0, '0));
          seq.push_back(make_instr(K_ADDR, '0, 1'b0, blk, 0, 0, 0, 0, '0));
          repeat (units) begin
            seq.push_back(make_instr(K_CMD, OP_ER_EXEC, 1'b0, 0, 0, 0, 0, 0, '0));
            seq.push_back(make_instr(K_WAIT, '0, 1'b0, 0, 0, 0, 0, 0, tmo_regs.er));
          end
        end
      end
      ACT_READ, ACT_PROG: begin
        span  = size + byt;
        units = (span + PAGE_BYTES - 1) / PAGE_BYTES;
        if (units > MAX_UNITS) begin
          seq.push_back(make_instr(K_REJ, '0, 1'b0, 0, 0, 0, 0, 0, '0));
        end else begin
          seq.push_back(make_instr(K_CMD, (action == ACT_PROG) ? OP_PG_SETUP : OP_RD_SETUP,
                                   1'b0, 0, 0, 0, 0, 0, '0));
          seq.push_back(make_instr(K_ADDR, '0, 1'b1, blk, pg, byt, 0, 0, '0));
          remaining = size;
          cursor    = 0;
          // first chunk only reaches the end of the start page
          avail     = PAGE_BYTES - byt;
          while (remaining > 0) begin
            len = (remaining < avail) ? remaining : avail;
            if (action == ACT_PROG) begin
              seq.push_back(make_instr(K_DIN, '0, 1'b0, 0, 0, 0, len, cursor, '0));
              seq.push_back(make_instr(K_CMD, OP_PG_EXEC, 1'b0, 0, 0, 0, 0, 0, '0));
              seq.push_back(make_instr(K_WAIT, '0, 1'b0, 0, 0, 0, 0, 0, tmo_regs.pg));
            end else begin
              seq.push_back(make_instr(K_CMD, OP_RD_EXEC, 1'b0, 0, 0, 0, 0, 0, '0));
              seq.push_back(make_instr(K_WAIT, '0, 1'b0, 0, 0, 0, 0, 0, tmo_regs.rd));
              seq.push_back(make_instr(K_DOUT, '0, 1'b0, 0, 0, 0, len, cursor, '0));
            end
            remaining -= len;
            cursor    += len;
            avail      = PAGE_BYTES;
          end
        end
      end
      default: begin
        seq.push_back(make_instr(K_REJ, '0, 1'b0, 0, 0, 0, 0, 0, '0));
      end
    endcase
    it = seq[seq.size()-1];
    it.last = 1'b1;
    seq[seq.size()-1] = it;
    foreach (seq[i]) instr_expect_q.push_back(seq[i]);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tmo_regs.rd = RST_READ_TMO;
      tmo_regs.pg = RST_PROG_TMO;
      tmo_regs.er = RST_ERASE_TMO;
      fail_count  = 0;
      instr_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_READ_TMO:  tmo_regs.rd = pwdata[TMO_W-1:0];
          REG_PROG_TMO:  tmo_regs.pg = pwdata[TMO_W-1:0];
          REG_ERASE_TMO: tmo_regs.er = pwdata[TMO_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expand_request(in_ch.action, in_ch.offset, in_ch.transfer_size);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (instr_expect_q.size() == 0) begin
          $error("instruction beat with nothing expected: kind %0d", out_ch.instr_kind);
          fail_count++;
        end else begin
          got_instr = instr_expect_q.pop_front();
          compare_field("instr_kind", 32'(got_instr.kind), 32'(out_ch.instr_kind));
          compare_field("opcode", 32'(got_instr.opcode), 32'(out_ch.opcode));
          compare_field("addr_full", 32'(got_instr.full), 32'(out_ch.addr_full));
          compare_field("addr_block", 32'(got_instr.blk), 32'(out_ch.addr_block));
          compare_field("addr_page", 32'(got_instr.pg), 32'(out_ch.addr_page));
          compare_field("addr_byte", 32'(got_instr.byt), 32'(out_ch.addr_byte));
          compare_field("chunk_length", 32'(got_instr.len), 32'(out_ch.chunk_length));
          compare_field("buffer_offset", 32'(got_instr.bufpos),
                        32'(out_ch.buffer_offset));
          compare_field("wait_timeout", 32'(got_instr.tmo), 32'(out_ch.wait_timeout));
          compare_field("last", 32'(got_instr.last), 32'(out_ch.last));
        end
      end
    end
    expected_left = instr_expect_q.size();
  end

endmodule

// ----- dv/tb_nand_operation_sequencer.sv -----
`timescale 1ns / 100ps

module tb_nand_operation_sequencer;
  import nos_pkg::*;

  localparam int BLOCK_BYTES    = DEF_PAGE_BYTES * DEF_PAGES_PER_BLOCK;
  localparam int MAX_DATA_BYTES = DEF_MAX_UNITS * DEF_PAGE_BYTES;
  localparam int MAX_ERASE_SPAN = DEF_MAX_UNITS * BLOCK_BYTES;
  localparam int PHASE_ITEMS    = 133;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int CYCLE_LIMIT    = 6000000;

  // action code the block does not define
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          fail_count;
  int          expected_left;
  int unsigned cycle_count;
  bit          no_stall;
  bit          hold_off_req;

  nos_in_if  in_ch ();
  nos_out_if out_ch ();

  nand_operation_sequencer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nos_sequence_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side: bursts of ready, random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // called and returns at a falling edge
  task automatic reg_write(input nos_reg_t idx, input logic [APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [OFFSET_W-1:0] offset,
                              input logic [SIZE_W-1:0] size);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.action        = act;
    in_ch.offset        = offset;
    in_ch.transfer_size = size;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [ACTION_W-1:0] act;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
    int r, s;
    for (int i = 0; i < count; i++) begin
      r      = $urandom_range(0, 99);
      s      = $urandom_range(0, 99);
      offset = OFFSET_W'($urandom);
      size   = SIZE_W'($urandom);
      if (r < 60) begin
        act = $urandom_range(0, 1) ? ACT_PROG : ACT_READ;
        if (s < 70) size = SIZE_W'($urandom_range(0, 768));
        else if (s < 92) begin
          size = SIZE_W'($urandom_range(0, MAX_DATA_BYTES - offset % DEF_PAGE_BYTES));
        end
      end else if (r < 88) begin
        act = ACT_ERASE;
        if (s < 70) size = SIZE_W'($urandom_range(0, 3 * BLOCK_BYTES));
        else if (s < 92) begin
          size = SIZE_W'($urandom_range(0, MAX_ERASE_SPAN - offset % BLOCK_BYTES));
        end
      end else if (r < 94) begin
        act = ACT_UNDEF;
      end else begin
        act = ACTION_W'($urandom);
      end
      send_request(act, offset, size);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_READ;
    in_ch.offset        = '0;
    in_ch.transfer_size = '0;
    no_stall            = 1'b0;
    hold_off_req        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, registers at their reset values
    send_request(ACT_READ, 0, 0);
    send_request(ACT_PROG, 0, 0);
    send_request(ACT_ERASE, 0, 0);
    send_request(ACT_ERASE, 100, 0);
    send_request(ACT_READ, 0, 1);
    send_request(ACT_READ, 255, 2);
    send_request(ACT_PROG, 0, SIZE_W'(DEF_PAGE_BYTES));
    send_request(ACT_PROG, 10, SIZE_W'(MAX_DATA_BYTES - 10));
    send_request(ACT_PROG, 10, SIZE_W'(MAX_DATA_BYTES - 9));
    send_request(ACT_READ, 0, SIZE_W'(MAX_DATA_BYTES));
    send_request(ACT_READ, 0, SIZE_W'(MAX_DATA_BYTES + 1));
    send_request(ACT_ERASE, 0, SIZE_W'(MAX_ERASE_SPAN));
    send_request(ACT_ERASE, 1, SIZE_W'(MAX_ERASE_SPAN));
    send_request(ACT_ERASE, OFFSET_W'(BLOCK_BYTES - 1), 1);
    send_request(ACT_ERASE, OFFSET_W'(BLOCK_BYTES - 1), 2);
    send_request(ACT_READ, '1, 1);
    send_request(ACT_PROG, '1, SIZE_W'(DEF_PAGE_BYTES + 1));
    send_request(ACT_ERASE, '1, 0);
    send_request(ACT_ERASE, '1, '1);
    send_request(ACT_READ, 0, '1);
    send_request(ACT_UNDEF, 0, 0);
    send_request(ACT_UNDEF, '1, '1);

    wait_idle();
    reg_write(REG_READ_TMO, '0);
    reg_write(REG_PROG_TMO, '0);
    reg_write(REG_ERASE_TMO, '0);
    random_phase(PHASE_ITEMS);

    // upper bits of the write data must be dropped
    wait_idle();
    reg_write(REG_READ_TMO, '1);
    reg_write(REG_PROG_TMO, '1);
    reg_write(REG_ERASE_TMO, '1);
    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);

    wait_idle();
    reg_write(REG_READ_TMO, $urandom);
    reg_write(REG_PROG_TMO, $urandom);
    reg_write(REG_ERASE_TMO, $urandom);
    no_stall = 1'b1;
    random_phase(PHASE_ITEMS / 2);
    no_stall = 1'b0;
    random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
